// ----- rtl/mlr_pkg.sv -----
`default_nettype none

package mlr_pkg;

  // Default coordinate width of the rasterizer.
  localparam int COORD_BITS_DEF = 12;

  // Entries in the queue between the setup front and the stepping back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // Control bits of one queued request, classified by the front.
  typedef struct packed {
    cmd_t cmd;
    logic dir_x_neg;
    logic dir_y_neg;
    logic steep;
    logic nonzero;
  } mlr_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mlr_front.sv -----
`default_nettype none

module mlr_front #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        cmd,
  input  wire logic [COORD_BITS-1:0]       start_x,
  input  wire logic [COORD_BITS-1:0]       start_y,
  input  wire logic [COORD_BITS-1:0]       end_x,
  input  wire logic [COORD_BITS-1:0]       end_y,
  input  wire logic                        q_full,
  output logic                             q_push,
  output mlr_pkg::mlr_ctl_t                q_ctl,
  output logic [7*COORD_BITS+4:0]          q_data
);

  localparam int DW = COORD_BITS + 1;   // delta width
  localparam int EW = COORD_BITS + 3;   // decision width

  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic [DW-1:0] ax;
  logic [DW-1:0] ay;
  logic [DW-1:0] major;
  logic [DW-1:0] minor;
  logic [EW-1:0] decision;
  logic          steep;

  always_comb begin
    // Signed differences with one guard bit, then magnitudes.
    dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    ax = dx[DW-1] ? (~dx + {{(DW-1){1'b0}}, 1'b1}) : dx;
    ay = dy[DW-1] ? (~dy + {{(DW-1){1'b0}}, 1'b1}) : dy;
    steep = ay > ax;
    major = steep ? ay : ax;
    minor = steep ? ax : ay;
    // 2*minor - major
    decision = {1'b0, minor, 1'b0} - {2'b00, major};

    q_ctl.cmd       = mlr_pkg::cmd_t'(cmd);
    q_ctl.dir_x_neg = dx[DW-1];
    q_ctl.dir_y_neg = dy[DW-1];
    q_ctl.steep     = steep;
    q_ctl.nonzero   = (dx != '0) || (dy != '0);

    q_data   = {start_x, start_y, end_x, end_y, major, minor, decision};
    in_stall = q_full;
    q_push   = in_valid && !q_full;
  end

endmodule

`default_nettype wire

// ----- rtl/mlr_queue.sv -----
`default_nettype none

module mlr_queue #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire mlr_pkg::mlr_ctl_t           push_ctl,
  input  wire logic [7*COORD_BITS+4:0]     push_data,
  output logic                             full,
  output logic                             head_valid,
  output mlr_pkg::mlr_ctl_t                head_ctl,
  output logic [7*COORD_BITS+4:0]          head_data,
  input  wire logic                        pop
);

  localparam int DEPTH = mlr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mlr_pkg::mlr_ctl_t          ctl_mem  [DEPTH];
  logic [7*COORD_BITS+4:0]    data_mem [DEPTH];
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic [CW-1:0]              count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_ctl   = ctl_mem[rd_ptr];
  assign head_data  = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= push_ctl;
      data_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && head_valid) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop && head_valid})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mlr_back.sv -----
`default_nettype none

module mlr_back #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire mlr_pkg::mlr_ctl_t           q_ctl,
  input  wire logic [7*COORD_BITS+4:0]     q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [COORD_BITS-1:0]            pixel_x,
  output logic [COORD_BITS-1:0]            pixel_y,
  output logic                             last
);

  localparam int N  = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 3;

  // Line state
  logic [N-1:0]  cur_x;
  logic [N-1:0]  cur_y;
  logic [N-1:0]  goal_x;
  logic [N-1:0]  goal_y;
  logic [DW-1:0] delta_major;
  logic [DW-1:0] delta_minor;
  logic [EW-1:0] decision;
  logic          dir_x_neg;
  logic          dir_y_neg;
  logic          steep;
  logic          active;

  // Unpacked head request
  logic [N-1:0]  ld_sx;
  logic [N-1:0]  ld_sy;
  logic [N-1:0]  ld_ex;
  logic [N-1:0]  ld_ey;
  logic [DW-1:0] ld_major;
  logic [DW-1:0] ld_minor;
  logic [EW-1:0] ld_decision;

  logic          head_step;
  logic          out_free;
  logic          emit;
  logic          minor_step;
  logic [N-1:0]  ux;
  logic [N-1:0]  uy;
  logic [EW-1:0] dm2;
  logic [EW-1:0] dj2;
  logic [EW-1:0] decision_next;
  logic [N-1:0]  cur_x_next;
  logic [N-1:0]  cur_y_next;
  logic          done;

  always_comb begin
    {ld_sx, ld_sy, ld_ex, ld_ey, ld_major, ld_minor, ld_decision} = q_data;

    head_step = (q_ctl.cmd == mlr_pkg::CMD_STEP);
    out_free  = !out_valid || !out_stall;
    emit      = q_valid && head_step && active && out_free;
    // Loads and idle steps retire at once; a live step waits for the output slot.
    q_pop     = q_valid && (!head_step || !active || out_free);

    minor_step = !decision[EW-1];
    dm2 = {1'b0, delta_minor, 1'b0};
    dj2 = {1'b0, delta_major, 1'b0};
    decision_next = minor_step ? (decision + dm2 - dj2) : (decision + dm2);

    ux = dir_x_neg ? {N{1'b1}} : {{(N-1){1'b0}}, 1'b1};
    uy = dir_y_neg ? {N{1'b1}} : {{(N-1){1'b0}}, 1'b1};
    cur_x_next = (!steep || minor_step) ? (cur_x + ux) : cur_x;
    cur_y_next = ( steep || minor_step) ? (cur_y + uy) : cur_y;
    done = steep ? (cur_y_next == goal_y) : (cur_x_next == goal_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        if (!head_step) begin
          active <= q_ctl.nonzero;
        end else if (active) begin
          active <= !done;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !head_step) begin
      cur_x       <= ld_sx;
      cur_y       <= ld_sy;
      goal_x      <= ld_ex;
      goal_y      <= ld_ey;
      delta_major <= ld_major;
      delta_minor <= ld_minor;
      decision    <= ld_decision;
      dir_x_neg   <= q_ctl.dir_x_neg;
      dir_y_neg   <= q_ctl.dir_y_neg;
      steep       <= q_ctl.steep;
    end else if (emit) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
    if (emit) begin
      pixel_x <= cur_x_next;
      pixel_y <= cur_y_next;
      last    <= done;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/midpoint_line_rasterizer.sv -----
`default_nettype none
// Midpoint line rasterizer.
// Input channel (in_valid / in_stall): each request carries cmd and the four
// endpoint coordinates. cmd = load sets up a new line from start to end and
// produces no pixel; cmd = step produces the next pixel of the active line.
// The start point is never emitted; the pixel that reaches the end point has
// last set and closes the line. A step with no active line, or a load whose
// endpoints are equal, produces nothing.
// Output channel (out_valid / out_stall): pixel_x, pixel_y, last.
// A step accepted on the input is first written into the queue; at the queue
// head the stepping unit computes its pixel into the output register, as soon
// as that register is free.
// Throughput: one request per cycle while out_stall is low; the front computes
// the line setup combinationally, the back one add and compare per pixel.
// A two-entry queue separates the setup front from the stepping back, so a
// stalled receiver holds the output register and the queue absorbs up to two
// more requests before in_stall rises.
// Reset (rst, synchronous, active high) drops any active line, empties the
// queue and clears out_valid; in_stall is low the cycle after reset.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         cmd,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      pixel_x,
  output logic signed [COORD_BITS-1:0]      pixel_y,
  output logic                              last
);

  // Front to queue
  logic                        q_push;
  logic                        q_full;
  mlr_pkg::mlr_ctl_t           push_ctl;
  logic [7*COORD_BITS+4:0]     push_data;

  // Queue to back
  logic                        head_valid;
  mlr_pkg::mlr_ctl_t           head_ctl;
  logic [7*COORD_BITS+4:0]     head_data;
  logic                        q_pop;

  logic [COORD_BITS-1:0]       px;
  logic [COORD_BITS-1:0]       py;

  // Classify the request and precompute deltas, directions and decision term.
  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctl    (push_ctl),
    .q_data   (push_data)
  );

  // Hold classified requests until the stepping unit can take them.
  mlr_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ctl   (push_ctl),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_data  (head_data),
    .pop        (q_pop)
  );

  // Load line state or advance one pixel, and drive the output register.
  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_ctl     (head_ctl),
    .q_data    (head_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (px),
    .pixel_y   (py),
    .last      (last)
  );

  assign pixel_x = px;
  assign pixel_y = py;

endmodule

`default_nettype wire

// ----- rtl/mlr_checker.sv -----
`default_nettype none

module mlr_checker #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] pixel_x,
  input wire logic [COORD_BITS-1:0] pixel_y,
  input wire logic                  last
);

  // Hold a stalled pixel unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(last))
    else $error("stalled pixel changed or dropped");

  // Leave reset with an empty queue and no pixel pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // The queue only fills after taking a request.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an accepted request");

  // No pixel appears right after reset.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst))
    else $error("pixel emitted right after reset");

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y),
  .last      (last)
);

`default_nettype wire

// ----- test/midpoint_line_rasterizer_tb.sv -----
`default_nettype none

module midpoint_line_rasterizer_tb;

  localparam int CW   = mlr_pkg::COORD_BITS_DEF;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  typedef logic signed [CW-1:0] coord_t;

  // One pixel as the output port presents it.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  mlr_pkg::cmd_t cmd;
  coord_t        start_x;
  coord_t        start_y;
  coord_t        end_x;
  coord_t        end_y;
  logic          out_valid;
  logic          out_stall;
  coord_t        pixel_x;
  coord_t        pixel_y;
  logic          last;

  midpoint_line_rasterizer #(.COORD_BITS(CW)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every request
  // waiting out the longest gap and every pixel the longest stall.
  initial begin
    #(8 * 500000);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line tracer: own copy of the rasterizer state, advanced once per request.
  // ---------------------------------------------------------------------------
  coord_t                ln_cur_x, ln_cur_y, ln_goal_x, ln_goal_y;
  logic [CW:0]           ln_major, ln_minor;
  logic signed [CW+2:0]  ln_decision;
  logic                  ln_dir_x_neg, ln_dir_y_neg, ln_steep, ln_active;

  pixel_t pending_pixels[$];   // pixels owed by the block, oldest first
  int     mismatch_count;
  int     requests_sent;
  logic   burst_mode;          // both sides run flat out while set

  // Set up a line on a load, or walk one pixel on a step.
  function automatic void trace_line(input mlr_pkg::cmd_t c, input coord_t sx,
                                     input coord_t sy, input coord_t ex, input coord_t ey,
                                     output bit emitted, output pixel_t px);
    int dx, dy, ax, ay;
    bit minor_step;
    emitted = 1'b0;
    px      = '{x: '0, y: '0, last: 1'b0};
    if (c == mlr_pkg::CMD_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      ln_cur_x     = sx;
      ln_cur_y     = sy;
      ln_goal_x    = ex;
      ln_goal_y    = ey;
      ln_dir_x_neg = dx < 0;
      ln_dir_y_neg = dy < 0;
      ln_steep     = ay > ax;
      ln_major     = (CW+1)'(ln_steep ? ay : ax);
      ln_minor     = (CW+1)'(ln_steep ? ax : ay);
      ln_decision  = (CW+3)'(2 * int'(ln_minor) - int'(ln_major));
      ln_active    = (dx != 0) || (dy != 0);
      return;
    end
    // A step with no line in progress leaves everything as it is.
    if (!ln_active) return;
    minor_step = ln_decision >= 0;
    if (minor_step)
      ln_decision = (CW+3)'(ln_decision + 2 * (int'(ln_minor) - int'(ln_major)));
    else ln_decision = (CW+3)'(ln_decision + 2 * int'(ln_minor));
    if (ln_steep) begin
      ln_cur_y = coord_t'(ln_cur_y + (ln_dir_y_neg ? -1 : 1));
      if (minor_step) ln_cur_x = coord_t'(ln_cur_x + (ln_dir_x_neg ? -1 : 1));
      px.last = ln_cur_y == ln_goal_y;
    end else begin
      ln_cur_x = coord_t'(ln_cur_x + (ln_dir_x_neg ? -1 : 1));
      if (minor_step) ln_cur_y = coord_t'(ln_cur_y + (ln_dir_y_neg ? -1 : 1));
      px.last = ln_cur_x == ln_goal_x;
    end
    px.x    = ln_cur_x;
    px.y    = ln_cur_y;
    emitted = 1'b1;
    if (px.last) ln_active = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    // Keep the log short on a badly broken block; the count still grows.
    if (mismatch_count <= 40)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Watch both channels. All values sampled here are the ones that held just
  // before the edge, since both sides update only through nonblocking writes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    pixel_t want_px;
    pixel_t new_px;
    bit     emitted;
    if (!rst) begin
      // Check a delivered pixel first, so a request taken at this same edge
      // can never stand in for it.
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel with none owed, x", int'(pixel_x), 0);
        end else begin
          want_px = pending_pixels.pop_front();
          if (pixel_x !== want_px.x) report_mismatch("pixel_x", int'(pixel_x), int'(want_px.x));
          if (pixel_y !== want_px.y) report_mismatch("pixel_y", int'(pixel_y), int'(want_px.y));
          if (last !== want_px.last) report_mismatch("last", int'(last), int'(want_px.last));
        end
      end
      if (in_valid && !in_stall) begin
        trace_line(cmd, start_x, start_y, end_x, end_y, emitted, new_px);
        if (emitted) pending_pixels.push_back(new_px);
      end
    end
  end

  // Idle length for either side: mostly none, often a few, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: stall in bursts, with long stall-free stretches mixed in.
  int stall_left;
  int run_left;
  always @(posedge clk) begin
    if (rst || burst_mode) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 4);
        stall_left = idle_cycles();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers. Each call starts and ends at a rising edge.
  // ---------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Move the end point back inside the coordinate range by mirroring the delta.
  function automatic coord_t fit_end(input int base, input int delta);
    int e;
    e = base + delta;
    if (e > CMAX || e < CMIN) e = base - delta;
    return coord_t'(e);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input mlr_pkg::cmd_t c, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Step request: the endpoint fields are don't-care, so fill them with noise.
  task automatic send_step();
    send_request(mlr_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic load_and_trace(input coord_t sx, input coord_t sy, input coord_t ex,
                                input coord_t ey, input int nsteps);
    send_request(mlr_pkg::CMD_LOAD, sx, sy, ex, ey);
    repeat (nsteps) send_step();
  endtask

  // Drop valid and hold until every owed pixel has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    // Step right after reset: no line, no pixel.
    send_step();
    // Zero-length line: load leaves nothing active, the step stays silent.
    load_and_trace(coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(5), 1);
    // Horizontal at the negative corner, then one step past the end.
    load_and_trace(coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMIN + 3), coord_t'(CMIN), 4);
    // Vertical at the positive corner, walking downward.
    load_and_trace(coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMAX - 3), 3);
    // Equal deltas: every step is diagonal.
    load_and_trace(coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(3), 3);
    // Full span corner to corner, then replace it mid-line with a steep one.
    load_and_trace(coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), 2);
    load_and_trace(coord_t'(1), coord_t'(1), coord_t'(-1), coord_t'(4), 3);
  endtask

  // Hold the sender off until the block has nothing left in flight, twice.
  task automatic test_drain_pause();
    repeat (2) begin
      load_and_trace(coord_t'(-7), coord_t'(12), coord_t'(2), coord_t'(6), 9);
      drain_pixels();
    end
  endtask

  // No idling on either side: a few lines pushed at full rate.
  task automatic test_full_rate();
    int i;
    burst_mode <= 1'b1;
    for (i = 0; i < 4; i++)
      load_and_trace(coord_t'(i * 5 - 9), coord_t'(-i), coord_t'(11 - i * 3),
                     coord_t'(i * 4), 12);
    burst_mode <= 1'b0;
  endtask

  task automatic test_random_lines(input int target);
    int kind, span, r;
    int sx, sy, dx, dy, ex, ey, ax, ay, major, nsteps;
    while (requests_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        // Noise: a lone request of either kind with arbitrary fields.
        send_request(mlr_pkg::cmd_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
      end else begin
        sx = int'(rand_coord());
        sy = int'(rand_coord());
        if (kind < 17) begin
          // Long line anywhere in the plane; it gets cut off below.
          ex = int'(rand_coord());
          ey = int'(rand_coord());
        end else begin
          span = ($urandom_range(0, 9) == 0) ? 200 : 24;
          dx   = int'($urandom_range(0, 2 * span)) - span;
          dy   = int'($urandom_range(0, 2 * span)) - span;
          if (kind < 24) dx = 0;
          else if (kind < 31) dy = 0;
          else if (kind < 38) dy = ($urandom_range(0, 1) == 1) ? dx : -dx;
          ex = int'(fit_end(sx, dx));
          ey = int'(fit_end(sy, dy));
        end
        ax     = (ex - sx < 0) ? sx - ex : ex - sx;
        ay     = (ey - sy < 0) ? sy - ey : ey - sy;
        major  = (ax > ay) ? ax : ay;
        nsteps = major;
        r      = $urandom_range(0, 9);
        if (r == 0) nsteps = $urandom_range(0, major);              // reload mid-line
        else if (r == 1) nsteps = major + $urandom_range(1, 3);     // step past the end
        if (kind < 17 && nsteps > 40) nsteps = $urandom_range(5, 40);
        load_and_trace(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey), nsteps);
        if ($urandom_range(0, 29) == 0) drain_pixels();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    cmd            <= mlr_pkg::CMD_LOAD;
    start_x        <= '0;
    start_y        <= '0;
    end_x          <= '0;
    end_y          <= '0;
    out_stall      <= 1'b0;
    burst_mode     <= 1'b0;
    stall_left     = 0;
    run_left       = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    ln_cur_x = '0; ln_cur_y = '0; ln_goal_x = '0; ln_goal_y = '0;
    ln_major = '0; ln_minor = '0; ln_decision = '0;
    ln_dir_x_neg = 1'b0; ln_dir_y_neg = 1'b0; ln_steep = 1'b0; ln_active = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_drain_pause();
    test_full_rate();
    test_random_lines(950);

    // Let the last pixels out, then wait past the pipeline depth so a stray
    // pixel still gets caught.
    drain_pixels();
    repeat (12) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
